/* rtl/tlca_pkg.sv */
// ----------------------------------------------------------------------------
// tlca_pkg
// shared types, field widths and request codes of the tree distance engine
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 10;

    localparam int KIND_W       = 2;
    localparam int NODE_FIELD_W = 10;
    localparam int DEPTH_W      = 10;
    localparam int DIST_W       = 40;
    localparam int LEN_W        = 41;
    localparam int COUNT_W      = 10;

    localparam logic [KIND_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 10'd1;

    typedef struct packed {
        logic [KIND_W-1:0]       req_type;
        logic [NODE_FIELD_W-1:0] node_a;
        logic [NODE_FIELD_W-1:0] node_b;
        logic [NODE_FIELD_W-1:0] parent_node;
        logic [DEPTH_W-1:0]      node_depth;
        logic [DIST_W-1:0]       root_distance;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] ack_kind;
        logic [LEN_W-1:0]  path_length;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] node_count;
    } cfg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [DIST_W-1:0]  root_dist;
    } node_entry_t;

endpackage

/* rtl/tlca_chan_if.sv */
// ----------------------------------------------------------------------------
// tlca_chan_if
// valid/ready channel carrying one payload struct per transfer
// ----------------------------------------------------------------------------
interface tlca_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/tlca_anc_ram.sv */
// ----------------------------------------------------------------------------
// tlca_anc_ram
// ancestor table storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module tlca_anc_ram
    import tlca_pkg::*;
#(
    parameter int ADDR_W = $clog2(DEF_MAX_NODES) + $clog2(DEF_LIFT_LEVELS),
    parameter int DATA_W = $clog2(DEF_MAX_NODES),
    parameter int DEPTH  = DEF_MAX_NODES << $clog2(DEF_LIFT_LEVELS)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/tree_lca_distance_query_top.sv */
// ----------------------------------------------------------------------------
// tree_lca_distance_query_top
// binary-lifting lowest common ancestor engine returning weighted tree distance
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | transfer when
//  req     | in  | req_type node_a node_b parent_node depth root_dist | valid & ready
//  rsp     | out | ack_kind path_length                               | valid & ready
//  cfg     | in  | node_count                                         | valid & ready
//
//  one item at a time; load and unused kinds go straight to the result; a query lifts the deeper
//  node (one table read per lifting step), then lifts both unless the lifted node meets the other.
//  a build fills each level for nodes 1..last, last = min(node_count, MAX_NODES-1), with one
//  table read per node and level plus a pipeline drain per level.
//  reset clears control only; table and node store hold garbage until loaded.
//  a result waiting in the output register holds the engine in its final state.
// ----------------------------------------------------------------------------
module tree_lca_distance_query_top
    import tlca_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  logic        clk,
    input  logic        rst_n,
    tlca_chan_if.sink   req,
    tlca_chan_if.source rsp,
    tlca_chan_if.sink   cfg
);

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LVL_W     = $clog2(LIFT_LEVELS);
    localparam int ANC_AW    = NODE_W + LVL_W;
    localparam int ANC_DEPTH = MAX_NODES << LVL_W;
    localparam int WIDE_W    = ((NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W) + 1;
    localparam int CMP_W     = ((LIFT_LEVELS > DEPTH_W) ? LIFT_LEVELS : DEPTH_W) + 1;
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LIFT_LEVELS - 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_QB     = 10'b0000000010,
        ST_QS     = 10'b0000000100,
        ST_LIFT   = 10'b0000001000,
        ST_CLIMB  = 10'b0000010000,
        ST_PARENT = 10'b0000100000,
        ST_DIST   = 10'b0001000000,
        ST_BUILD  = 10'b0010000000,
        ST_DRAIN  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    function automatic logic [NODE_W-1:0] clip_node(input logic [NODE_FIELD_W-1:0] x);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(x);
        return (w < WIDE_W'(MAX_NODES)) ? NODE_W'(w) : '0;
    endfunction

    function automatic logic [NODE_W-1:0] last_node(input logic [COUNT_W-1:0] cnt);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(cnt);
        return (w >= WIDE_W'(MAX_NODES - 1)) ? NODE_W'(MAX_NODES - 1) : NODE_W'(w);
    endfunction

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [LVL_W-1:0]    lv_reg, lv_next;
    logic [DEPTH_W-1:0]  dep_v_reg, dep_v_next;
    logic [DEPTH_W-1:0]  dep_a_reg, dep_a_next;
    logic [DIST_W-1:0]   rd_a_reg, rd_a_next;
    logic [LEN_W-1:0]    sum_reg, sum_next;
    logic [NODE_W-1:0]   bi_reg, bi_next;
    logic [LVL_W-1:0]    bj_reg, bj_next;
    logic [NODE_W-1:0]   last_reg, last_next;
    logic                s1_valid_reg, s1_valid_next;
    logic [NODE_W-1:0]   s1_node_reg, s1_node_next;
    logic                s2_valid_reg, s2_valid_next;
    logic [NODE_W-1:0]   s2_node_reg, s2_node_next;
    logic                s2_tzero_reg, s2_tzero_next;
    logic [COUNT_W-1:0]  node_count_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_data_reg, rsp_data_next;

    node_entry_t         ns_mem [MAX_NODES];
    node_entry_t         ns_q_reg;
    logic [NODE_W-1:0]   ns_node_reg;
    logic [NODE_W-1:0]   ns_raddr;
    logic                ns_we;
    logic [NODE_W-1:0]   ns_waddr;
    node_entry_t         ns_wdata;

    logic                anc_we;
    logic [ANC_AW-1:0]   anc_waddr;
    logic [NODE_W-1:0]   anc_wdata;
    logic [ANC_AW-1:0]   anc_raddr_a;
    logic [ANC_AW-1:0]   anc_raddr_b;
    logic [NODE_W-1:0]   anc_qa;
    logic [NODE_W-1:0]   anc_qb;

    logic [DEPTH_W-1:0]  ns_dep;
    logic [DIST_W-1:0]   ns_dist;
    logic [NODE_W-1:0]   anc_u;
    logic [NODE_W-1:0]   anc_v;
    logic                lift_ok;
    logic [NODE_W-1:0]   u_lift;
    logic                climb_ok;
    logic [NODE_W-1:0]   u_climb;
    logic [NODE_W-1:0]   v_climb;
    logic [NODE_W-1:0]   a_clip;
    logic [LEN_W-1:0]    sub_val;

    tlca_anc_ram #(
        .ADDR_W (ANC_AW),
        .DATA_W (NODE_W),
        .DEPTH  (ANC_DEPTH)
    ) u_anc_ram (
        .clk     (clk),
        .we      (anc_we),
        .waddr   (anc_waddr),
        .wdata   (anc_wdata),
        .raddr_a (anc_raddr_a),
        .raddr_b (anc_raddr_b),
        .rdata_a (anc_qa),
        .rdata_b (anc_qb)
    );

    // node store: depth and root distance per node
    always_ff @(posedge clk)
    begin
        if (ns_we)
        begin
            ns_mem[ns_waddr] <= ns_wdata;
        end
        ns_q_reg    <= ns_mem[ns_raddr];
        ns_node_reg <= ns_raddr;
    end

    // node zero reads as all zero
    assign ns_dep  = (ns_node_reg == '0) ? '0 : ns_q_reg.depth;
    assign ns_dist = (ns_node_reg == '0) ? '0 : ns_q_reg.root_dist;
    assign anc_u   = (u_reg == '0) ? '0 : anc_qa;
    assign anc_v   = (v_reg == '0) ? '0 : anc_qb;

    assign lift_ok  = CMP_W'(ns_dep) >= (CMP_W'(dep_v_reg) + (CMP_W'(1) << lv_reg));
    assign u_lift   = lift_ok ? anc_u : u_reg;
    assign climb_ok = (anc_u != '0) && (anc_v != '0) && (anc_u != anc_v);
    assign u_climb  = climb_ok ? anc_u : u_reg;
    assign v_climb  = climb_ok ? anc_v : v_reg;
    assign a_clip   = clip_node(req.payload.node_a);
    assign sub_val  = {ns_dist, 1'b0};

    assign req.ready   = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        len_next      = len_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        b_next        = b_reg;
        lv_next       = lv_reg;
        dep_v_next    = dep_v_reg;
        dep_a_next    = dep_a_reg;
        rd_a_next     = rd_a_reg;
        sum_next      = sum_reg;
        bi_next       = bi_reg;
        bj_next       = bj_reg;
        last_next     = last_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next = rsp_data_reg;

        ns_raddr    = u_reg;
        ns_we       = 1'b0;
        ns_waddr    = a_clip;
        ns_wdata    = '{depth: req.payload.node_depth, root_dist: req.payload.root_distance};
        anc_we      = 1'b0;
        anc_waddr   = {a_clip, LVL_W'(0)};
        anc_wdata   = clip_node(req.payload.parent_node);
        anc_raddr_a = {u_reg, lv_reg};
        anc_raddr_b = {v_reg, lv_reg};

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                ns_raddr = a_clip;
                if (req.valid)
                begin
                    kind_next = req.payload.req_type;
                    len_next  = '0;
                    u_next    = a_clip;
                    b_next    = clip_node(req.payload.node_b);
                    case (req.payload.req_type)
                        REQ_LOAD:
                        begin
                            if (a_clip != '0)
                            begin
                                ns_we  = 1'b1;
                                anc_we = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        REQ_BUILD:
                        begin
                            bi_next    = NODE_W'(1);
                            bj_next    = LVL_W'(1);
                            last_next  = last_node(node_count_reg);
                            state_next = (last_node(node_count_reg) == '0) ? ST_DONE : ST_BUILD;
                        end
                        REQ_QUERY:
                        begin
                            state_next = ST_QB;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_QB:
            begin
                dep_a_next = ns_dep;
                rd_a_next  = ns_dist;
                ns_raddr   = b_reg;
                state_next = ST_QS;
            end
            ST_QS:
            begin
                sum_next = LEN_W'(rd_a_reg) + LEN_W'(ns_dist);
                lv_next  = TOP_LVL;
                if (dep_a_reg < ns_dep)
                begin
                    u_next      = b_reg;
                    v_next      = u_reg;
                    dep_v_next  = dep_a_reg;
                    ns_raddr    = b_reg;
                    anc_raddr_a = {b_reg, TOP_LVL};
                end
                else
                begin
                    v_next      = b_reg;
                    dep_v_next  = ns_dep;
                    ns_raddr    = u_reg;
                    anc_raddr_a = {u_reg, TOP_LVL};
                end
                state_next = ST_LIFT;
            end
            ST_LIFT:
            begin
                u_next = u_lift;
                if (lv_reg == '0)
                begin
                    if (u_lift == v_reg)
                    begin
                        ns_raddr   = u_lift;
                        state_next = ST_DIST;
                    end
                    else
                    begin
                        lv_next     = TOP_LVL;
                        anc_raddr_a = {u_lift, TOP_LVL};
                        anc_raddr_b = {v_reg, TOP_LVL};
                        state_next  = ST_CLIMB;
                    end
                end
                else
                begin
                    lv_next     = lv_reg - LVL_W'(1);
                    ns_raddr    = u_lift;
                    anc_raddr_a = {u_lift, lv_reg - LVL_W'(1)};
                end
            end
            ST_CLIMB:
            begin
                u_next = u_climb;
                v_next = v_climb;
                if (lv_reg == '0)
                begin
                    anc_raddr_a = {u_climb, LVL_W'(0)};
                    state_next  = ST_PARENT;
                end
                else
                begin
                    lv_next     = lv_reg - LVL_W'(1);
                    anc_raddr_a = {u_climb, lv_reg - LVL_W'(1)};
                    anc_raddr_b = {v_climb, lv_reg - LVL_W'(1)};
                end
            end
            ST_PARENT:
            begin
                ns_raddr   = anc_u;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                len_next   = (sum_reg >= sub_val) ? (sum_reg - sub_val) : '0;
                state_next = ST_DONE;
            end
            ST_BUILD:
            begin
                anc_raddr_a = {bi_reg, bj_reg - LVL_W'(1)};
                if (bi_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    bi_next = bi_reg + NODE_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    if (bj_reg == TOP_LVL)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bj_next    = bj_reg + LVL_W'(1);
                        bi_next    = NODE_W'(1);
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '{ack_kind: kind_reg, path_length: len_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // build pipeline: read anc(i, j-1), then anc of that, then write level j
        s1_valid_next = (state_reg == ST_BUILD);
        s1_node_next  = bi_reg;
        s2_valid_next = s1_valid_reg;
        s2_node_next  = s1_node_reg;
        s2_tzero_next = (anc_qa == '0);
        if (s1_valid_reg)
        begin
            anc_raddr_b = {anc_qa, bj_reg - LVL_W'(1)};
        end
        if (s2_valid_reg)
        begin
            anc_we    = 1'b1;
            anc_waddr = {s2_node_reg, bj_reg};
            anc_wdata = s2_tzero_reg ? '0 : anc_qb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                node_count_reg <= cfg.payload.node_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        len_reg      <= len_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        b_reg        <= b_next;
        lv_reg       <= lv_next;
        dep_v_reg    <= dep_v_next;
        dep_a_reg    <= dep_a_next;
        rd_a_reg     <= rd_a_next;
        sum_reg      <= sum_next;
        bi_reg       <= bi_next;
        bj_reg       <= bj_next;
        last_reg     <= last_next;
        s1_node_reg  <= s1_node_next;
        s2_node_reg  <= s2_node_next;
        s2_tzero_reg <= s2_tzero_next;
        rsp_data_reg <= rsp_data_next;
    end

`ifndef SYNTHESIS
    a_build_pipe_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == ST_BUILD || state_reg == ST_DRAIN))
        else $error("build pipeline active outside build");

    a_level_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && state_next == ST_BUILD) |=> !s2_valid_reg)
        else $error("next level started before previous level was written");

    a_climb_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLIMB) |-> (u_reg != v_reg))
        else $error("joint lifting reached equal nodes");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rsp_valid_reg && !rsp.ready) |=> (state_reg == ST_DONE))
        else $error("result register overwritten while occupied");

    a_len_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_data_reg.ack_kind == REQ_QUERY || rsp_data_reg.path_length == '0))
        else $error("non-query transfer carries a path length");
`endif

endmodule
